// ----- hw/rtl/pcbtb_pkg.sv -----
package pcbtb_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] REG_W_LLC_RD   = 3'd0;
  localparam logic [2:0] REG_W_LLC_WR   = 3'd1;
  localparam logic [2:0] REG_W_MEM_RD   = 3'd2;
  localparam logic [2:0] REG_W_MEM_WR   = 3'd3;
  localparam logic [2:0] REG_BUDGET     = 3'd4;
  localparam logic [2:0] REG_PERIOD     = 3'd5;
  localparam logic [2:0] REG_CAP_MULT   = 3'd6;

  localparam logic [1:0] DEC_NONE   = 2'd0;
  localparam logic [1:0] DEC_PAUSE  = 2'd1;
  localparam logic [1:0] DEC_RESUME = 2'd2;

  localparam logic signed [31:0] LVL_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] LVL_MIN = 32'sh80000000;

  typedef struct packed {
    logic [15:0] w_llc_rd;
    logic [15:0] w_llc_wr;
    logic [15:0] w_mem_rd;
    logic [15:0] w_mem_wr;
    logic [15:0] budget;
    logic [15:0] period;
    logic [7:0]  cap_mult;
  } pcbtb_cfg_t;

  localparam pcbtb_cfg_t CFG_RESET = '{
    w_llc_rd: 16'd10000,
    w_llc_wr: 16'd0,
    w_mem_rd: 16'd6120,
    w_mem_wr: 16'd4400,
    budget:   16'd86,
    period:   16'd2000,
    cap_mult: 8'd2
  };

  typedef struct packed {
    logic signed [31:0] bucket;
    logic               thr;
    logic [31:0]        cnt;
  } pcbtb_ent_t;

endpackage

// ----- hw/rtl/pcbtb_if.sv -----
interface pcbtb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  core_index;
  logic [30:0] llc_reads;
  logic [30:0] llc_writes;
  logic [30:0] mem_reads;
  logic [30:0] mem_writes;
  logic        acknowledged;

  modport source(output valid, core_index, llc_reads, llc_writes, mem_reads, mem_writes,
                 acknowledged, input ready);
  modport sink(input valid, core_index, llc_reads, llc_writes, mem_reads, mem_writes,
               acknowledged, output ready);
endinterface

interface pcbtb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_core;
  logic [1:0]         decision;
  logic signed [31:0] token_level;
  logic               is_throttled;
  logic [31:0]        interrupts_sent;

  modport source(output valid, result_core, decision, token_level, is_throttled,
                 interrupts_sent, input ready);
  modport sink(input valid, result_core, decision, token_level, is_throttled,
               interrupts_sent, output ready);
endinterface

// ----- hw/rtl/pcbtb_ram.sv -----
module pcbtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                           clk,
  input  logic                                           we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                               rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- hw/rtl/pcbtb_regs.sv -----
module pcbtb_regs
  import pcbtb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output pcbtb_cfg_t        cfg
);
  pcbtb_cfg_t cfg_r;
  pcbtb_cfg_t cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx = cfg_paddr[4:2];
  assign wr  = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_W_LLC_RD: cfg_nxt.w_llc_rd = cfg_pwdata[15:0];
        REG_W_LLC_WR: cfg_nxt.w_llc_wr = cfg_pwdata[15:0];
        REG_W_MEM_RD: cfg_nxt.w_mem_rd = cfg_pwdata[15:0];
        REG_W_MEM_WR: cfg_nxt.w_mem_wr = cfg_pwdata[15:0];
        REG_BUDGET:   cfg_nxt.budget   = cfg_pwdata[15:0];
        REG_PERIOD:   cfg_nxt.period   = cfg_pwdata[15:0];
        REG_CAP_MULT: cfg_nxt.cap_mult = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_W_LLC_RD: cfg_prdata = {16'd0, cfg_r.w_llc_rd};
      REG_W_LLC_WR: cfg_prdata = {16'd0, cfg_r.w_llc_wr};
      REG_W_MEM_RD: cfg_prdata = {16'd0, cfg_r.w_mem_rd};
      REG_W_MEM_WR: cfg_prdata = {16'd0, cfg_r.w_mem_wr};
      REG_BUDGET:   cfg_prdata = {16'd0, cfg_r.budget};
      REG_PERIOD:   cfg_prdata = {16'd0, cfg_r.period};
      REG_CAP_MULT: cfg_prdata = {24'd0, cfg_r.cap_mult};
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;
endmodule

// ----- hw/rtl/pcbtb_core.sv -----
module pcbtb_core
  import pcbtb_pkg::*;
#(
  parameter int NUM_POLICED = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pcbtb_cfg_t  cfg,
  pcbtb_in_if.sink    in_ch,
  pcbtb_out_if.source out_ch
);
  localparam int IDX_W = (NUM_POLICED > 1) ? $clog2(NUM_POLICED) : 1;
  localparam int ENT_W = $bits(pcbtb_ent_t);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_BASE = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;

  logic [2:0]             st_r, st_nxt;
  logic [NUM_POLICED-1:0] vld_r;
  logic                   acc;
  logic                   fire;

  logic [1:0]        core_r;
  logic [IDX_W-1:0]  idx_r;
  logic              oor_r;
  logic              ack_r;
  logic [30:0]       lr_r, lw_r, mr_r, mw_r;

  logic [46:0]       p0_r, p1_r, p2_r, p3_r;
  logic [31:0]       refill_r;
  pcbtb_ent_t        ent_r;
  logic [47:0]       s01_r, s23_r;
  logic [39:0]       cap_r;
  logic [48:0]       usage_r;
  logic signed [33:0] base_r;

  logic [ENT_W-1:0]  rdata;
  logic [IDX_W-1:0]  raddr;
  pcbtb_ent_t        wr_ent;
  logic              we;

  logic signed [50:0] lvl_full, lvl_cap;
  logic signed [31:0] lvl;
  logic [1:0]         dec;

  logic               out_valid_r;
  logic [1:0]         res_core_r, dec_r;
  logic signed [31:0] lvl_r;
  logic               thr_r;
  logic [31:0]        cnt_r;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign acc  = in_ch.valid && in_ch.ready;
  assign fire = (st_r == ST_UPD) && (!out_valid_r || out_ch.ready);
  assign raddr = IDX_W'(in_ch.core_index);

  pcbtb_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_POLICED)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wr_ent),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (acc) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_BASE;
      ST_BASE: st_nxt = ST_UPD;
      ST_UPD:  if (fire) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lvl_full = 51'(base_r) - $signed({2'b00, usage_r});
    lvl_cap  = (lvl_full > $signed({11'd0, cap_r})) ? $signed({11'd0, cap_r}) : lvl_full;
    if (lvl_cap > 51'(LVL_MAX)) begin
      lvl = LVL_MAX;
    end else if (lvl_cap < 51'(LVL_MIN)) begin
      lvl = LVL_MIN;
    end else begin
      lvl = lvl_cap[31:0];
    end
    wr_ent        = ent_r;
    wr_ent.bucket = lvl;
    dec           = DEC_NONE;
    if (ack_r) begin
      if (lvl[31] && !ent_r.thr) begin
        dec        = DEC_PAUSE;
        wr_ent.thr = 1'b1;
        wr_ent.cnt = ent_r.cnt + 32'd1;
      end else if (!lvl[31] && ent_r.thr) begin
        dec        = DEC_RESUME;
        wr_ent.thr = 1'b0;
        wr_ent.cnt = ent_r.cnt + 32'd1;
      end
    end
    we = fire && !oor_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (we) begin
        vld_r[idx_r] <= 1'b1;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (acc) begin
      core_r <= in_ch.core_index;
      idx_r  <= raddr;
      oor_r  <= 32'(in_ch.core_index) >= NUM_POLICED;
      ack_r  <= in_ch.acknowledged;
      lr_r   <= in_ch.llc_reads;
      lw_r   <= in_ch.llc_writes;
      mr_r   <= in_ch.mem_reads;
      mw_r   <= in_ch.mem_writes;
    end
    if (st_r == ST_MUL) begin
      p0_r     <= cfg.w_llc_rd * lr_r;
      p1_r     <= cfg.w_llc_wr * lw_r;
      p2_r     <= cfg.w_mem_rd * mr_r;
      p3_r     <= cfg.w_mem_wr * mw_r;
      refill_r <= cfg.budget * cfg.period;
      ent_r    <= vld_r[idx_r] ? pcbtb_ent_t'(rdata) : '0;
    end
    if (st_r == ST_SUM) begin
      s01_r <= p0_r + p1_r;
      s23_r <= p2_r + p3_r;
      cap_r <= cfg.cap_mult * refill_r;
    end
    if (st_r == ST_BASE) begin
      usage_r <= s01_r + s23_r;
      base_r  <= 34'(ent_r.bucket) + $signed({2'b00, refill_r});
    end
    if (fire) begin
      res_core_r <= core_r;
      if (oor_r) begin
        dec_r <= DEC_NONE;
        lvl_r <= '0;
        thr_r <= 1'b0;
        cnt_r <= '0;
      end else begin
        dec_r <= dec;
        lvl_r <= lvl;
        thr_r <= wr_ent.thr;
        cnt_r <= wr_ent.cnt;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_core     = res_core_r;
  assign out_ch.decision        = dec_r;
  assign out_ch.token_level     = lvl_r;
  assign out_ch.is_throttled    = thr_r;
  assign out_ch.interrupts_sent = cnt_r;
endmodule

// ----- hw/rtl/per_core_bandwidth_token_bucket_top.sv -----
// Per-core memory bandwidth regulator. Each request carries one core's LLC and memory
// read/write counts for a polling period; the block weights them, refills that core's
// token bucket by budget_rate*period_cycles, subtracts the usage, limits it to
// cap_multiplier*period_cycles*budget_rate and to the signed 32-bit range, and returns a
// pause or resume decision with the new level, throttled flag and interrupt count. Per-core
// state sits in one RAM entry read at acceptance and written back at the end of the item.
// Each item passes in order through products with the RAM entry latched, partial sums, usage
// and refill add, and update; the next request is taken the cycle after the result is loaded
// into the output register, so a new request is not taken while one is in flight, and the
// update waits while the output register holds a result not yet taken. All per-core state
// reads as zero after reset through per-entry valid flags, so no clearing pass is needed.
module per_core_bandwidth_token_bucket_top
  import pcbtb_pkg::*;
#(
  parameter int NUM_POLICED = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  pcbtb_in_if.sink          in_ch,
  pcbtb_out_if.source       out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);
  pcbtb_cfg_t cfg;

  pcbtb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pcbtb_core #(
    .NUM_POLICED(NUM_POLICED)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import pcbtb_pkg::*;

  localparam int N_CORES = 4;
  localparam logic [30:0] CNT_MAX = 31'h7FFFFFFF;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  core;
    logic [30:0] lr;
    logic [30:0] lw;
    logic [30:0] mr;
    logic [30:0] mw;
    logic        ack;
  } counters_t;

  typedef struct packed {
    logic [1:0]         core;
    logic [1:0]         decision;
    logic signed [31:0] level;
    logic               thr;
    logic [31:0]        cnt;
  } verdict_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    counters_t   req;
    bit          typed;
    verdict_t    want;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pcbtb_in_if  in_ch();
  pcbtb_out_if out_ch();

  per_core_bandwidth_token_bucket_top #(
    .NUM_POLICED(N_CORES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  pcbtb_cfg_t         cfg_now = CFG_RESET;
  logic signed [31:0] bucket_lvl [N_CORES];
  logic               thr_flag [N_CORES];
  logic [31:0]        irq_count [N_CORES];
  verdict_t           expected_verdicts [$];
  plan_row_t          plan [$];
  int                 mismatches = 0;
  int                 results_seen = 0;
  bit                 tx_burst = 1'b0;
  bit                 rx_burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic verdict_t regulate(counters_t r);
    verdict_t    v;
    logic [63:0] usage;
    logic [63:0] refill;
    logic [63:0] cap;
    longint      lvl;
    v = '0;
    v.core = r.core;
    v.decision = DEC_NONE;
    if (int'(r.core) >= N_CORES) return v;
    usage = 64'(cfg_now.w_llc_rd) * 64'(r.lr) + 64'(cfg_now.w_llc_wr) * 64'(r.lw)
          + 64'(cfg_now.w_mem_rd) * 64'(r.mr) + 64'(cfg_now.w_mem_wr) * 64'(r.mw);
    refill = 64'(cfg_now.budget) * 64'(cfg_now.period);
    cap = 64'(cfg_now.cap_mult) * refill;
    lvl = longint'(bucket_lvl[r.core]) + longint'(refill) - longint'(usage);
    if (lvl > longint'(cap)) lvl = longint'(cap);
    if (lvl > longint'(LVL_MAX)) lvl = longint'(LVL_MAX);
    if (lvl < longint'(LVL_MIN)) lvl = longint'(LVL_MIN);
    bucket_lvl[r.core] = lvl[31:0];
    if (r.ack) begin
      if (lvl < 0 && !thr_flag[r.core]) begin
        v.decision = DEC_PAUSE;
        thr_flag[r.core] = 1'b1;
        irq_count[r.core] = irq_count[r.core] + 32'd1;
      end else if (lvl >= 0 && thr_flag[r.core]) begin
        v.decision = DEC_RESUME;
        thr_flag[r.core] = 1'b0;
        irq_count[r.core] = irq_count[r.core] + 32'd1;
      end
    end
    v.level = bucket_lvl[r.core];
    v.thr = thr_flag[r.core];
    v.cnt = irq_count[r.core];
    return v;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] c, logic [30:0] lr, logic [30:0] lw,
                                         logic [30:0] mr, logic [30:0] mw, logic ack);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.reg_idx = REG_W_LLC_RD;
    p.reg_val = '0;
    p.req = '{core: c, lr: lr, lw: lw, mr: mr, mw: mw, ack: ack};
    p.typed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t typed_row(logic [1:0] c, logic [30:0] lr, logic [30:0] lw,
                                          logic [30:0] mr, logic [30:0] mw, logic ack,
                                          logic [1:0] dec, logic signed [31:0] lvl,
                                          logic thr, logic [31:0] cnt);
    plan_row_t p;
    p = item_row(c, lr, lw, mr, mw, ack);
    p.typed = 1'b1;
    p.want = '{core: c, decision: dec, level: lvl, thr: thr, cnt: cnt};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [31:0] val);
    plan_row_t p;
    p = item_row(2'd0, '0, '0, '0, '0, 1'b0);
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic logic [31:0] pick_reg(int unsigned lo, int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [30:0] pick_count(logic [63:0] scale);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 31'($urandom());
    if (r < 15) return '0;
    return 31'($urandom_range(0, 32'(scale)));
  endfunction

  // counts scaled so the usage hovers around the refill and the buckets swing both ways
  function automatic counters_t draw_counters();
    counters_t   r;
    logic [63:0] wsum;
    logic [63:0] scale;
    wsum = 64'(cfg_now.w_llc_rd) + 64'(cfg_now.w_llc_wr) + 64'(cfg_now.w_mem_rd)
         + 64'(cfg_now.w_mem_wr);
    scale = (64'(cfg_now.budget) * 64'(cfg_now.period) * 2) / (wsum + 1);
    if (scale < 1) scale = 1;
    if (scale > 64'(CNT_MAX)) scale = 64'(CNT_MAX);
    r.core = 2'($urandom_range(0, 3));
    r.lr = pick_count(scale);
    r.lw = pick_count(scale);
    r.mr = pick_count(scale);
    r.mw = pick_count(scale);
    r.ack = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 50) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", field, got, want));
  endtask

  task automatic settle();
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    in_ch.valid = 1'b0;
    settle();
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = CFG_AW'(32'(idx) * 4);
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      REG_W_LLC_RD: cfg_now.w_llc_rd = val[15:0];
      REG_W_LLC_WR: cfg_now.w_llc_wr = val[15:0];
      REG_W_MEM_RD: cfg_now.w_mem_rd = val[15:0];
      REG_W_MEM_WR: cfg_now.w_mem_wr = val[15:0];
      REG_BUDGET:   cfg_now.budget = val[15:0];
      REG_PERIOD:   cfg_now.period = val[15:0];
      REG_CAP_MULT: cfg_now.cap_mult = val[7:0];
      default: ;
    endcase
  endtask

  task automatic send_request(counters_t r, bit typed, verdict_t want);
    int       gap;
    verdict_t v;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.core_index = r.core;
    in_ch.llc_reads = r.lr;
    in_ch.llc_writes = r.lw;
    in_ch.mem_reads = r.mr;
    in_ch.mem_writes = r.mw;
    in_ch.acknowledged = r.ack;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    v = regulate(r);
    expected_verdicts.push_back(typed ? want : v);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    verdict_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result for core %0d", out_ch.result_core));
      end else begin
        w = expected_verdicts.pop_front();
        check_field("result_core", 32'(out_ch.result_core), 32'(w.core));
        check_field("decision", 32'(out_ch.decision), 32'(w.decision));
        check_field("token_level", out_ch.token_level, w.level);
        check_field("is_throttled", 32'(out_ch.is_throttled), 32'(w.thr));
        check_field("interrupts_sent", out_ch.interrupts_sent, w.cnt);
      end
    end
  end

  // result side, with one long hold so the block backs up into its input
  initial begin : result_sink
    int hold;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (hold > 0) begin
        out_ch.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    verdict_t blank;
    blank = '0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.core_index = '0;
    in_ch.llc_reads = '0;
    in_ch.llc_writes = '0;
    in_ch.mem_reads = '0;
    in_ch.mem_writes = '0;
    in_ch.acknowledged = 1'b0;
    for (int c = 0; c < N_CORES; c++) begin
      bucket_lvl[c] = '0;
      thr_flag[c] = 1'b0;
      irq_count[c] = '0;
    end

    // reset settings: refill 172000, cap 344000
    plan.push_back(typed_row(2'd0, '0, '0, '0, '0, 1'b1, DEC_NONE, 32'sd172000, 1'b0, 32'd0));
    plan.push_back(typed_row(2'd0, '0, '0, '0, '0, 1'b1, DEC_NONE, 32'sd344000, 1'b0, 32'd0));
    plan.push_back(typed_row(2'd0, '0, '0, '0, '0, 1'b1, DEC_NONE, 32'sd344000, 1'b0, 32'd0));
    plan.push_back(typed_row(2'd1, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1,
                             DEC_PAUSE, LVL_MIN, 1'b1, 32'd1));
    plan.push_back(item_row(2'd1, '0, '0, '0, '0, 1'b0));
    plan.push_back(typed_row(2'd2, '0, CNT_MAX, '0, '0, 1'b1, DEC_NONE, 32'sd172000,
                             1'b0, 32'd0));
    plan.push_back(item_row(2'd3, '0, '0, 31'd1, '0, 1'b0));
    // cap beyond the signed range, refill saturates high
    plan.push_back(cfg_row(REG_BUDGET, 32'd65535));
    plan.push_back(cfg_row(REG_PERIOD, 32'd65535));
    plan.push_back(cfg_row(REG_CAP_MULT, 32'd255));
    plan.push_back(item_row(2'd1, '0, '0, '0, '0, 1'b1));
    plan.push_back(typed_row(2'd1, '0, '0, '0, '0, 1'b1, DEC_NONE, LVL_MAX, 1'b0, 32'd2));
    plan.push_back(typed_row(2'd0, '0, '0, '0, '0, 1'b1, DEC_NONE, LVL_MAX, 1'b0, 32'd0));
    // zero period, heaviest weights
    plan.push_back(cfg_row(REG_PERIOD, 32'd0));
    plan.push_back(cfg_row(REG_W_LLC_RD, 32'd65535));
    plan.push_back(cfg_row(REG_W_LLC_WR, 32'd65535));
    plan.push_back(cfg_row(REG_W_MEM_RD, 32'd65535));
    plan.push_back(cfg_row(REG_W_MEM_WR, 32'd65535));
    plan.push_back(item_row(2'd0, '0, '0, '0, 31'd1, 1'b1));
    plan.push_back(typed_row(2'd0, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1,
                             DEC_PAUSE, LVL_MIN, 1'b1, 32'd1));
    plan.push_back(typed_row(2'd0, '0, '0, '0, '0, 1'b1, DEC_NONE, LVL_MIN, 1'b1, 32'd1));
    // zero cap
    plan.push_back(cfg_row(REG_PERIOD, 32'd1));
    plan.push_back(cfg_row(REG_BUDGET, 32'd0));
    plan.push_back(cfg_row(REG_CAP_MULT, 32'd0));
    plan.push_back(typed_row(2'd2, '0, '0, '0, '0, 1'b1, DEC_NONE, 32'sd0, 1'b0, 32'd0));
    plan.push_back(item_row(2'd3, CNT_MAX, '0, '0, '0, 1'b1));
    // zero weights, smallest refill and cap
    plan.push_back(cfg_row(REG_W_LLC_RD, 32'd0));
    plan.push_back(cfg_row(REG_W_LLC_WR, 32'd0));
    plan.push_back(cfg_row(REG_W_MEM_RD, 32'd0));
    plan.push_back(cfg_row(REG_W_MEM_WR, 32'd0));
    plan.push_back(cfg_row(REG_BUDGET, 32'd1));
    plan.push_back(cfg_row(REG_CAP_MULT, 32'd1));
    plan.push_back(item_row(2'd3, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, 1'b1));
    plan.push_back(item_row(2'd3, '0, '0, '0, '0, 1'b0));
    // back to reset settings
    plan.push_back(cfg_row(REG_W_LLC_RD, 32'd10000));
    plan.push_back(cfg_row(REG_W_LLC_WR, 32'd0));
    plan.push_back(cfg_row(REG_W_MEM_RD, 32'd6120));
    plan.push_back(cfg_row(REG_W_MEM_WR, 32'd4400));
    plan.push_back(cfg_row(REG_BUDGET, 32'd86));
    plan.push_back(cfg_row(REG_PERIOD, 32'd2000));
    plan.push_back(cfg_row(REG_CAP_MULT, 32'd2));
    plan.push_back(item_row(2'd1, 31'd17, 31'd5, 31'd9, 31'd3, 1'b1));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_request(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_W_LLC_RD, pick_reg(0, 65535));
      write_reg(REG_W_LLC_WR, pick_reg(0, 65535));
      write_reg(REG_W_MEM_RD, pick_reg(0, 65535));
      write_reg(REG_W_MEM_WR, pick_reg(0, 65535));
      write_reg(REG_BUDGET, pick_reg(0, 65535));
      write_reg(REG_PERIOD, pick_reg(1, 65535));
      write_reg(REG_CAP_MULT, pick_reg(0, 255));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) send_request(draw_counters(), 1'b0, blank);
    end

    in_ch.valid = 1'b0;
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/pcbtb_pkg.sv
hw/rtl/pcbtb_if.sv
hw/rtl/pcbtb_ram.sv
hw/rtl/pcbtb_regs.sv
hw/rtl/pcbtb_core.sv
hw/rtl/per_core_bandwidth_token_bucket_top.sv
tb/sv/tb_top.sv
